FILE: rtl/core/hbd_pkg.sv
// shared types and constants for the huffman bitstream decoder
package hbd_pkg;

  localparam int ACC_W  = 16;  // accumulator and code width
  localparam int BYTE_W = 8;   // data byte width
  localparam int POS_W  = 3;   // bit position inside a byte
  localparam int LEN_W  = 5;   // code length width
  localparam int SYM_W  = 8;   // symbol width
  localparam int ACT_W  = 2;   // action code width
  localparam int IDX_W  = 8;   // entry index port width

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [ACC_W-1:0] code;
    logic [LEN_W-1:0] length;
    logic [SYM_W-1:0] symbol;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic hit_chk;
  } match_ctrl_t;

endpackage

FILE: rtl/core/hbd_ram.sv
// generic simple dual port ram with registered read
module hbd_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/hbd_match.sv
// per-segment match collector: one table entry per cycle against every bit run of a byte
module hbd_match import hbd_pkg::*; (
  input  logic                                   clk,
  input  logic                                   rst,
  input  match_ctrl_t                            ctrl,
  input  entry_t                                 entry,
  input  logic [BYTE_W-1:0]                      data,
  input  logic [ACC_W-1:0]                       acc_bits,
  input  logic [LEN_W-1:0]                       acc_len,
  output logic [BYTE_W-1:0][BYTE_W-1:0]          hit_vld,
  output logic [BYTE_W-1:0][BYTE_W-1:0][SYM_W-1:0] hit_sym
);

  // seg_hit[s][p]: run starting at bit position s (s = 0 means continuing the
  // accumulator) and ending at bit position p, msb first
  logic [BYTE_W-1:0][BYTE_W-1:0] seg_hit;
  logic [ACC_W+BYTE_W-1:0]       window;

  assign window = {acc_bits, data};

  always_comb begin
    logic [BYTE_W-1:0] run;
    logic [BYTE_W-1:0] mask;
    seg_hit = '0;
    for (int p = 0; p < BYTE_W; p++) begin
      seg_hit[0][p] = (entry.length == (acc_len + LEN_W'(p + 1))) &&
                      (entry.code == window[BYTE_W-1-p +: ACC_W]);
    end
    for (int s = 1; s < BYTE_W; s++) begin
      for (int p = 0; p < BYTE_W; p++) begin
        run  = data >> (BYTE_W - 1 - p);
        mask = {BYTE_W{1'b1}} >> (BYTE_W - (p + 1 - s));
        if (p >= s) begin
          seg_hit[s][p] = (entry.length == LEN_W'(p + 1 - s)) &&
                          (entry.code == ACC_W'(run & mask));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      hit_vld <= '0;
    end else if (ctrl.hit_chk) begin
      hit_vld <= hit_vld | seg_hit;
    end
  end

  // entries arrive in ascending index, so a later hit overrides
  always_ff @(posedge clk) begin
    if (ctrl.hit_chk) begin
      for (int s = 0; s < BYTE_W; s++) begin
        for (int p = 0; p < BYTE_W; p++) begin
          if (seg_hit[s][p]) begin
            hit_sym[s][p] <= entry.symbol;
          end
        end
      end
    end
  end

endmodule

FILE: rtl/core/huffman_bitstream_decoder.sv
// huffman bitstream decoder top level: table storage, scan, bit walk and result output
//
//   channel  signals                                                   direction
//   in       in_valid/in_ready, action, entry_index, code_bits,        into block
//            code_length, code_symbol, data_byte
//   out      out_valid/out_ready, decoded_symbol, code_error,          out of block
//            last_of_byte
//
// load, clear and unused codes are accepted in idle and leave the block in idle.
// a data byte is handled in the scan, walk and output states:
// the table ram is read one entry a cycle and each entry is matched against
// every bit run of the byte, then a serial walk resolves the byte bit by bit.
// results leave through out_valid/out_ready; a stall holds the block in output.
// reset clears the valid bits and the accumulator; table contents are kept.
module huffman_bitstream_decoder import hbd_pkg::*; #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_LEN  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [ACC_W-1:0]  code_bits,
  input  logic [LEN_W-1:0]  code_length,
  input  logic [SYM_W-1:0]  code_symbol,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SYM_W-1:0]  decoded_symbol,
  output logic              code_error,
  output logic              last_of_byte
);

  localparam int TI_W      = $clog2(TABLE_ENTRIES);
  localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int LEN_LIMIT = (MAX_CODE_LEN < ACC_W) ? MAX_CODE_LEN : ACC_W;
  localparam int SUM_W     = LEN_W + 1;
  localparam int SEG_W     = POS_W + 1;

  state_t state, state_next;

  logic                     in_acc;
  logic                     out_acc;
  logic                     idx_ok;
  logic                     ram_we;
  entry_t                   wr_entry;
  entry_t                   rd_entry;
  logic [TABLE_ENTRIES-1:0] tbl_vld;
  logic [CNT_W-1:0]         cnt;
  logic                     rd_en;
  logic                     rd_pend;
  logic                     ent_vld_q;
  match_ctrl_t              mctrl;
  logic [BYTE_W-1:0]        byte_q;
  logic [ACC_W-1:0]         acc_bits;
  logic [LEN_W-1:0]         acc_len;
  logic [BYTE_W-1:0][BYTE_W-1:0]            hit_vld;
  logic [BYTE_W-1:0][BYTE_W-1:0][SYM_W-1:0] hit_sym;

  logic [POS_W-1:0]         walk_pos;
  logic [SEG_W-1:0]         seg_start;
  logic [SEG_W-1:0]         seg_after;
  logic                     walk_en;
  logic                     walk_hit;
  logic                     walk_over;
  logic                     walk_emit;
  logic [SUM_W-1:0]         run_len0;
  logic [SEG_W-1:0]         run_len;
  logic [BYTE_W-1:0]        res_emit;
  logic [BYTE_W-1:0]        res_err;
  logic [BYTE_W-1:0][SYM_W-1:0] res_sym;
  logic [POS_W-1:0]         sel;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign idx_ok  = {1'b0, entry_index} < (IDX_W + 1)'(TABLE_ENTRIES);

  // table write: only the low code_length bits are kept
  assign ram_we          = in_acc && (action == ACT_LOAD) && idx_ok;
  assign wr_entry.code   = (code_length >= LEN_W'(ACC_W)) ? code_bits :
                           (code_bits & ~({ACC_W{1'b1}} << code_length));
  assign wr_entry.length = code_length;
  assign wr_entry.symbol = code_symbol;

  hbd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_index[TI_W-1:0]),
    .wdata (wr_entry),
    .raddr (cnt[TI_W-1:0]),
    .rdata (rd_entry)
  );

  hbd_match u_match (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mctrl),
    .entry    (rd_entry),
    .data     (byte_q),
    .acc_bits (acc_bits),
    .acc_len  (acc_len),
    .hit_vld  (hit_vld),
    .hit_sym  (hit_sym)
  );

  // serial walk over the byte, one bit position per cycle
  assign walk_hit  = hit_vld[seg_start[POS_W-1:0]][walk_pos];
  assign run_len0  = {1'b0, acc_len} + SUM_W'(walk_pos) + SUM_W'(1);
  assign run_len   = SEG_W'(walk_pos) + SEG_W'(1) - seg_start;
  assign walk_over = (seg_start == '0) ? (run_len0 >= SUM_W'(LEN_LIMIT)) :
                                         (SUM_W'(run_len) >= SUM_W'(LEN_LIMIT));
  assign walk_emit = walk_en && (walk_hit || walk_over);
  assign seg_after = walk_emit ? (SEG_W'(walk_pos) + SEG_W'(1)) : seg_start;

  // lowest pending position goes out first
  always_comb begin
    sel = '0;
    for (int p = BYTE_W - 1; p >= 0; p--) begin
      if (res_emit[p]) begin
        sel = POS_W'(p);
      end
    end
  end

  assign decoded_symbol = res_sym[sel];
  assign code_error     = res_err[sel];
  assign last_of_byte   = (res_emit & (res_emit - BYTE_W'(1))) == '0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && (action == ACT_DATA)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt == CNT_W'(TABLE_ENTRIES)) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_pos == '1) begin
          state_next = ((res_emit != '0) || walk_emit) ? S_OUT : S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready && last_of_byte) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    rd_en         = 1'b0;
    walk_en       = 1'b0;
    unique case (state)
      S_IDLE: in_ready  = 1'b1;
      S_SCAN: rd_en     = cnt < CNT_W'(TABLE_ENTRIES);
      S_WALK: walk_en   = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: in_ready = 1'b0;
    endcase
    mctrl.clear   = in_acc && (action == ACT_DATA);
    mctrl.hit_chk = rd_pend && ent_vld_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tbl_vld   <= '0;
      acc_bits  <= '0;
      acc_len   <= '0;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      walk_pos  <= '0;
      seg_start <= '0;
      res_emit  <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (in_acc) begin
        case (action)
          ACT_LOAD: begin
            if (idx_ok) begin
              tbl_vld[entry_index[TI_W-1:0]] <= 1'b1;
            end
          end
          ACT_CLEAR: begin
            tbl_vld  <= '0;
            acc_bits <= '0;
            acc_len  <= '0;
          end
          ACT_DATA: begin
            cnt       <= '0;
            walk_pos  <= '0;
            seg_start <= '0;
            res_emit  <= '0;
          end
          default: ;
        endcase
      end
      if (rd_en) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (walk_en) begin
        walk_pos  <= walk_pos + POS_W'(1);
        seg_start <= seg_after;
        if (walk_emit) begin
          res_emit[walk_pos] <= 1'b1;
        end
        // byte done: leftover bits become the accumulator
        if (walk_pos == '1) begin
          if (seg_after == '0) begin
            acc_bits <= {acc_bits[ACC_W-BYTE_W-1:0], byte_q};
            acc_len  <= acc_len + LEN_W'(BYTE_W);
          end else begin
            acc_bits <= ACC_W'(byte_q & ({BYTE_W{1'b1}} >> seg_after));
            acc_len  <= LEN_W'(BYTE_W) - LEN_W'(seg_after);
          end
        end
      end
      if (out_acc) begin
        res_emit <= res_emit & (res_emit - BYTE_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_vld_q <= tbl_vld[cnt[TI_W-1:0]];
    if (in_acc) begin
      byte_q <= data_byte;
    end
    if (walk_en) begin
      res_sym[walk_pos] <= walk_hit ? hit_sym[seg_start[POS_W-1:0]][walk_pos] : '0;
      res_err[walk_pos] <= !walk_hit;
    end
  end

endmodule

FILE: tb/sv/tb_huffman_bitstream_decoder.sv
// testbench for the huffman bitstream decoder: directed and random items checked by a predictor
`timescale 1ns / 100ps

module tb_huffman_bitstream_decoder;
  import hbd_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_LEN  = 16;
  localparam int CODE_LIMIT    = (MAX_CODE_LEN < ACC_W) ? MAX_CODE_LEN : ACC_W;
  localparam int RANDOM_ITEMS  = 120;
  localparam int DRAIN_CYCLES  = 400;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // receiver stall modes
  localparam int RX_ALWAYS   = 0;
  localparam int RX_PERIODIC = 1;
  localparam int RX_RANDOM   = 2;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  entry_index;
    logic [ACC_W-1:0]  code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]  code_symbol;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             error;
    logic             last;
  } symbol_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SYM_W-1:0] decoded_symbol;
  logic code_error;
  logic last_of_byte;
  item_t cur_item = '{default: '0};

  item_t input_items[$];
  symbol_result_t expected_symbols[$];
  int fail_count = 0;
  int accepted_count = 0;

  // predictor state
  logic             tbl_valid [TABLE_ENTRIES];
  logic [ACC_W-1:0] tbl_code  [TABLE_ENTRIES];
  logic [LEN_W-1:0] tbl_len   [TABLE_ENTRIES];
  logic [SYM_W-1:0] tbl_sym   [TABLE_ENTRIES];
  logic [ACC_W-1:0] acc_bits = '0;
  logic [LEN_W-1:0] acc_len = '0;

  huffman_bitstream_decoder #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(cur_item.action),
    .entry_index(cur_item.entry_index),
    .code_bits(cur_item.code_bits),
    .code_length(cur_item.code_length),
    .code_symbol(cur_item.code_symbol),
    .data_byte(cur_item.data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .decoded_symbol(decoded_symbol),
    .code_error(code_error),
    .last_of_byte(last_of_byte)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    // keep the log short when everything goes wrong
    if (fail_count <= 50) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  // applies one accepted item to the predictor and queues the symbols it yields
  function automatic void decode_item(input item_t it);
    symbol_result_t res [BYTE_W];
    int count;
    int hit;
    logic [ACC_W-1:0] mask;
    count = 0;
    case (it.action)
      ACT_LOAD: begin
        mask = (it.code_length >= ACC_W) ? {ACC_W{1'b1}} :
               ACC_W'((32'd1 << it.code_length) - 32'd1);
        if (int'(it.entry_index) < TABLE_ENTRIES) begin
          tbl_valid[it.entry_index] = 1'b1;
          tbl_len[it.entry_index]   = it.code_length;
          tbl_code[it.entry_index]  = it.code_bits & mask;
          tbl_sym[it.entry_index]   = it.code_symbol;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          tbl_valid[i] = 1'b0;
        end
        acc_bits = '0;
        acc_len  = '0;
      end
      ACT_DATA: begin
        for (int b = BYTE_W - 1; b >= 0; b--) begin
          acc_bits = {acc_bits[ACC_W-2:0], it.data_byte[b]};
          acc_len  = acc_len + 1'b1;
          hit = -1;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_len[i] == acc_len && tbl_code[i] == acc_bits) begin
              hit = i;
            end
          end
          if (hit >= 0) begin
            res[count] = '{symbol: tbl_sym[hit], error: 1'b0, last: 1'b0};
            count++;
            acc_bits = '0;
            acc_len  = '0;
          end else if (int'(acc_len) >= CODE_LIMIT) begin
            res[count] = '{symbol: '0, error: 1'b1, last: 1'b0};
            count++;
            acc_bits = '0;
            acc_len  = '0;
          end
        end
        if (count > 0) begin
          res[count-1].last = 1'b1;
        end
        for (int k = 0; k < count; k++) begin
          expected_symbols.push_back(res[k]);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // unused fields get random content, the block must ignore them
  function automatic item_t random_item(input logic [ACT_W-1:0] act);
    item_t it;
    it.action      = act;
    it.entry_index = IDX_W'($urandom);
    it.code_bits   = ACC_W'($urandom);
    it.code_length = LEN_W'($urandom);
    it.code_symbol = SYM_W'($urandom);
    it.data_byte   = BYTE_W'($urandom);
    return it;
  endfunction

  task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [ACC_W-1:0] code,
                            input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym);
    item_t it;
    it = random_item(ACT_LOAD);
    it.entry_index = idx;
    it.code_bits   = code;
    it.code_length = len;
    it.code_symbol = sym;
    input_items.push_back(it);
  endtask

  task automatic queue_data(input logic [BYTE_W-1:0] data);
    item_t it;
    it = random_item(ACT_DATA);
    it.data_byte = data;
    input_items.push_back(it);
  endtask

  task automatic queue_clear();
    input_items.push_back(random_item(ACT_CLEAR));
  endtask

  task automatic queue_unused();
    input_items.push_back(random_item(ACT_UNUSED));
  endtask

  // sender: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_item(cur_item);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (input_items.size() > 0) begin
          cur_item <= input_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: the stall pattern is picked again at random each time its run ends
  int rx_mode = RX_ALWAYS;
  int rx_left = 0;
  int rx_period = 2;
  int rx_count = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode   = $urandom_range(RX_ALWAYS, RX_RANDOM);
      rx_left   = $urandom_range(20, 300);
      rx_period = $urandom_range(2, 6);
    end else begin
      rx_left--;
    end
    rx_count++;
    case (rx_mode)
      RX_PERIODIC: out_ready <= (rx_count % rx_period) == 0;
      RX_RANDOM:   out_ready <= $urandom_range(0, 3) != 0;
      default:     out_ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    symbol_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected result symbol %h error %b last %b",
                                  decoded_symbol, code_error, last_of_byte));
      end else begin
        want = expected_symbols.pop_front();
        if (decoded_symbol !== want.symbol) begin
          report_mismatch($sformatf("decoded_symbol %h, expected %h",
                                    decoded_symbol, want.symbol));
        end
        if (code_error !== want.error) begin
          report_mismatch($sformatf("code_error %b, expected %b", code_error, want.error));
        end
        if (last_of_byte !== want.last) begin
          report_mismatch($sformatf("last_of_byte %b, expected %b", last_of_byte, want.last));
        end
      end
    end
  end

  initial begin
    int rand_items;
    int total_items;
    int splits;
    int j;
    int base;
    int stride;
    int drop;
    int nbytes;
    int k;
    logic [ACC_W-1:0] c;
    logic [ACC_W-1:0] mask;
    logic [ACC_W-1:0] leaf_code[$];
    int leaf_len[$];

    // directed part
    queue_clear();
    queue_data(8'h00);                          // empty table, no result
    queue_data(8'hFF);                          // limit reached without a match
    queue_load(8'd0, 16'hFFFE, 5'd1, 8'h00);    // "0", upper code bits ignored
    queue_load(8'd255, 16'h0002, 5'd2, 8'hFF);  // "10"
    queue_load(8'd10, 16'h0003, 5'd2, 8'h3C);   // "11"
    queue_load(8'd200, 16'hFFFF, 5'd2, 8'hA5);  // "11" again, higher slot wins
    queue_load(8'd20, 16'hFFFF, 5'd0, 8'h11);   // zero length never matches
    queue_load(8'd21, 16'hFFFF, 5'd31, 8'h22);  // past the limit
    queue_load(8'd22, 16'h0001, 5'd17, 8'h33);
    queue_unused();
    queue_data(8'h00);                          // eight results from one byte
    queue_data(8'h5F);                          // leaves one bit behind
    queue_data(8'h80);
    queue_clear();
    queue_load(8'd7, 16'hABCD, 5'd16, 8'h5A);   // full-width codes
    queue_load(8'd8, 16'hFFFF, 5'd16, 8'hC3);
    queue_data(8'hAB);
    queue_data(8'hCD);
    queue_data(8'hFF);
    queue_data(8'hFF);
    queue_data(8'h12);
    queue_data(8'h34);

    // random part: mostly complete prefix codes followed by data
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_clear();
        rand_items++;
      end
      leaf_code = '{16'd0, 16'd1};
      leaf_len  = '{1, 1};
      splits = $urandom_range(0, 7);
      repeat (splits) begin
        j = $urandom_range(0, leaf_code.size() - 1);
        if (leaf_len[j] < CODE_LIMIT) begin
          c = leaf_code[j];
          leaf_code[j] = c << 1;
          leaf_len[j]  = leaf_len[j] + 1;
          leaf_code.push_back((c << 1) | 16'd1);
          leaf_len.push_back(leaf_len[j]);
        end
      end
      base   = $urandom_range(0, 255);
      stride = 2 * $urandom_range(0, 127) + 1;
      // now and then one code is left out so errors show up
      drop = ($urandom_range(0, 4) == 0) ? $urandom_range(0, leaf_code.size() - 1) : -1;
      for (k = 0; k < leaf_code.size(); k++) begin
        if (k != drop) begin
          mask = ACC_W'((32'd1 << leaf_len[k]) - 32'd1);
          queue_load(IDX_W'((base + k * stride) % TABLE_ENTRIES),
                     (ACC_W'($urandom) & ~mask) | leaf_code[k],
                     LEN_W'(leaf_len[k]), SYM_W'($urandom));
          rand_items++;
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0:       j = 0;
          1:       j = $urandom_range(7, 16);
          default: j = $urandom_range(17, 31);
        endcase
        queue_load(IDX_W'($urandom), ACC_W'($urandom), LEN_W'(j), SYM_W'($urandom));
        rand_items++;
      end
      nbytes = $urandom_range(2, 8);
      repeat (nbytes) begin
        queue_data(BYTE_W'($urandom));
        rand_items++;
        if ($urandom_range(0, 15) == 0) begin
          queue_unused();
        end
      end
    end
    total_items = input_items.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items) @(posedge clk);
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/hbd_pkg.sv
rtl/core/hbd_ram.sv
rtl/core/hbd_match.sv
rtl/core/huffman_bitstream_decoder.sv
tb/sv/tb_huffman_bitstream_decoder.sv
